/* src/psp_pkg.sv */
// ----------------------------------------------------------------------------
// psp_pkg: shared types and constants for the format specifier parser
// Character codes, stage and status encodings, and the result bundle.
// ----------------------------------------------------------------------------
package psp_pkg;

  localparam int NUMBER_BITS_DEF = 31;
  localparam int WIDTH_W         = 31;
  localparam int PREC_W          = 32;

  typedef enum logic [2:0] {
    ST_FLAG,
    ST_WIDTH,
    ST_PREC,
    ST_LEN_H,
    ST_LEN_L,
    ST_CONV
  } stage_t;

  localparam logic [1:0] STATUS_OK       = 2'd0;
  localparam logic [1:0] STATUS_EOS      = 2'd1;
  localparam logic [1:0] STATUS_BAD_CONV = 2'd2;

  localparam logic [2:0] LEN_NONE = 3'd0;
  localparam logic [2:0] LEN_H    = 3'd1;
  localparam logic [2:0] LEN_HH   = 3'd2;
  localparam logic [2:0] LEN_L    = 3'd3;
  localparam logic [2:0] LEN_LL   = 3'd4;
  localparam logic [2:0] LEN_BIG_L = 3'd5;

  // Flag bit positions
  localparam int FLAG_ALT   = 0;
  localparam int FLAG_ZPAD  = 1;
  localparam int FLAG_LEFT  = 2;
  localparam int FLAG_BLANK = 3;
  localparam int FLAG_SIGN  = 4;

  localparam logic [7:0] CH_NUL     = 8'h00;
  localparam logic [7:0] CH_HASH    = 8'h23;
  localparam logic [7:0] CH_ZERO    = 8'h30;
  localparam logic [7:0] CH_NINE    = 8'h39;
  localparam logic [7:0] CH_MINUS   = 8'h2D;
  localparam logic [7:0] CH_PLUS    = 8'h2B;
  localparam logic [7:0] CH_SPACE   = 8'h20;
  localparam logic [7:0] CH_DOT     = 8'h2E;
  localparam logic [7:0] CH_LOW_H   = 8'h68;
  localparam logic [7:0] CH_LOW_L   = 8'h6C;
  localparam logic [7:0] CH_UP_L    = 8'h4C;
  localparam logic [7:0] CH_PERCENT = 8'h25;
  localparam logic [7:0] CH_C       = 8'h63;
  localparam logic [7:0] CH_S       = 8'h73;
  localparam logic [7:0] CH_P       = 8'h70;
  localparam logic [7:0] CH_D       = 8'h64;
  localparam logic [7:0] CH_I       = 8'h69;
  localparam logic [7:0] CH_O       = 8'h6F;
  localparam logic [7:0] CH_U       = 8'h75;
  localparam logic [7:0] CH_X_LOW   = 8'h78;
  localparam logic [7:0] CH_X_UP    = 8'h58;
  localparam logic [7:0] CH_F       = 8'h66;

  localparam logic [PREC_W-1:0] PREC_DEFAULT_F = 32'd6;

  typedef struct packed {
    logic [1:0]         status;
    logic               alt_form;
    logic               zero_pad;
    logic               left_align;
    logic               space_sign;
    logic               plus_sign;
    logic [WIDTH_W-1:0] field_width;
    logic [PREC_W-1:0]  precision;
    logic [2:0]         length_kind;
    logic [7:0]         conversion;
  } result_t;

  function automatic logic is_digit(input logic [7:0] c);
    return (c >= CH_ZERO) && (c <= CH_NINE);
  endfunction

  function automatic logic is_int_conv(input logic [7:0] c);
    return (c == CH_D) || (c == CH_I) || (c == CH_O) || (c == CH_U) ||
           (c == CH_X_LOW) || (c == CH_X_UP);
  endfunction

  function automatic logic is_known_conv(input logic [7:0] c);
    return is_int_conv(c) || (c == CH_C) || (c == CH_S) || (c == CH_P) ||
           (c == CH_F) || (c == CH_PERCENT);
  endfunction

endpackage

/* src/psp_dec_acc.sv */
// ----------------------------------------------------------------------------
// psp_dec_acc: saturating decimal accumulate
// Computes acc * 10 + digit, clamped to the all-ones value of the accumulator.
// ----------------------------------------------------------------------------
module psp_dec_acc #(
  parameter int NUMBER_BITS = 31
) (
  input  logic [NUMBER_BITS-1:0] acc,
  input  logic [7:0]             char_code,
  output logic [NUMBER_BITS-1:0] sum
);
  import psp_pkg::*;

  localparam int SUM_W = NUMBER_BITS + 4;

  logic [3:0]       digit;
  logic [SUM_W-1:0] acc_ext;
  logic [SUM_W-1:0] raw;
  logic [SUM_W-1:0] max_ext;

  assign digit   = 4'(char_code - CH_ZERO);
  assign acc_ext = SUM_W'(acc);
  // times ten as shift-and-add
  assign raw     = (acc_ext << 3) + (acc_ext << 1) + SUM_W'(digit);
  assign max_ext = SUM_W'({NUMBER_BITS{1'b1}});
  assign sum     = (raw > max_ext) ? {NUMBER_BITS{1'b1}} : raw[NUMBER_BITS-1:0];

endmodule

/* src/psp_core.sv */
// ----------------------------------------------------------------------------
// psp_core: specification state and per-character parse step
// Holds the parse stage and accumulated fields, applies one character per
// advance and builds the result when a specification closes.
// ----------------------------------------------------------------------------
module psp_core #(
  parameter int NUMBER_BITS = 31
) (
  input  logic              clk,
  input  logic              rst,
  input  logic              advance,
  input  logic [7:0]        char_code,
  input  logic              first,
  output logic              emit,
  output psp_pkg::result_t  res
);
  import psp_pkg::*;

  localparam int EXT_W = (NUMBER_BITS > PREC_W) ? NUMBER_BITS : PREC_W;

  stage_t                 stage, stage_next;
  logic [4:0]             flag_bits, flag_bits_next;
  logic [NUMBER_BITS-1:0] width_accum, width_accum_next;
  logic [NUMBER_BITS-1:0] prec_accum, prec_accum_next;
  logic                   prec_present, prec_present_next;
  logic [2:0]             length_code, length_code_next;

  stage_t                 st_cur;
  logic [4:0]             flags_cur;
  logic [NUMBER_BITS-1:0] w_cur, p_cur, w_sum, p_sum;
  logic                   pp_cur;
  logic [2:0]             len_cur;
  logic                   go_width, go_len, go_conv;
  logic [4:0]             res_flags;
  logic [EXT_W-1:0]       w_ext, p_ext;
  logic                   res_pp;

  // A first mark starts from a cleared specification
  assign st_cur    = first ? ST_FLAG : stage;
  assign flags_cur = first ? 5'd0 : flag_bits;
  assign w_cur     = first ? '0 : width_accum;
  assign p_cur     = first ? '0 : prec_accum;
  assign pp_cur    = first ? 1'b0 : prec_present;
  assign len_cur   = first ? LEN_NONE : length_code;

  psp_dec_acc #(.NUMBER_BITS(NUMBER_BITS)) u_width_acc (
    .acc(w_cur), .char_code(char_code), .sum(w_sum)
  );

  psp_dec_acc #(.NUMBER_BITS(NUMBER_BITS)) u_prec_acc (
    .acc(p_cur), .char_code(char_code), .sum(p_sum)
  );

  always_comb begin
    stage_next        = st_cur;
    flag_bits_next    = flags_cur;
    width_accum_next  = w_cur;
    prec_accum_next   = p_cur;
    prec_present_next = pp_cur;
    length_code_next  = len_cur;
    go_width   = 1'b0;
    go_len     = 1'b0;
    go_conv    = 1'b0;
    emit       = 1'b0;
    res_flags  = flags_cur;
    res_pp     = pp_cur;
    res.status = STATUS_OK;
    res.conversion = 8'd0;

    if (char_code == CH_NUL) begin
      emit       = 1'b1;
      res.status = STATUS_EOS;
    end else begin
      case (st_cur)
        ST_FLAG: begin
          if (char_code == CH_HASH)       flag_bits_next[FLAG_ALT]   = 1'b1;
          else if (char_code == CH_ZERO)  flag_bits_next[FLAG_ZPAD]  = 1'b1;
          else if (char_code == CH_MINUS) flag_bits_next[FLAG_LEFT]  = 1'b1;
          else if (char_code == CH_SPACE) flag_bits_next[FLAG_BLANK] = 1'b1;
          else if (char_code == CH_PLUS)  flag_bits_next[FLAG_SIGN]  = 1'b1;
          else                            go_width = 1'b1;
        end
        ST_WIDTH: go_width = 1'b1;
        ST_PREC: begin
          if (is_digit(char_code)) prec_accum_next = p_sum;
          else                     go_len = 1'b1;
        end
        ST_LEN_H: begin
          if (char_code == CH_LOW_H) begin
            length_code_next = LEN_HH;
            stage_next       = ST_CONV;
          end else begin
            go_conv = 1'b1;
          end
        end
        ST_LEN_L: begin
          if (char_code == CH_LOW_L) begin
            length_code_next = LEN_LL;
            stage_next       = ST_CONV;
          end else begin
            go_conv = 1'b1;
          end
        end
        default: go_conv = 1'b1;
      endcase

      // Hand the character on to later stages
      if (go_width) begin
        if (is_digit(char_code)) begin
          width_accum_next = w_sum;
          stage_next       = ST_WIDTH;
        end else if (char_code == CH_DOT) begin
          prec_present_next = 1'b1;
          prec_accum_next   = '0;
          stage_next        = ST_PREC;
        end else begin
          go_len = 1'b1;
        end
      end

      if (go_len) begin
        if (char_code == CH_LOW_H) begin
          length_code_next = LEN_H;
          stage_next       = ST_LEN_H;
        end else if (char_code == CH_LOW_L) begin
          length_code_next = LEN_L;
          stage_next       = ST_LEN_L;
        end else if (char_code == CH_UP_L) begin
          length_code_next = LEN_BIG_L;
          stage_next       = ST_CONV;
        end else begin
          go_conv = 1'b1;
        end
      end

      if (go_conv) begin
        emit = 1'b1;
        if (is_known_conv(char_code)) begin
          res.status     = STATUS_OK;
          res.conversion = char_code;
          if (!pp_cur) begin
            if (char_code == CH_F) res_pp = 1'b1;
          end else if (is_int_conv(char_code)) begin
            res_flags[FLAG_ZPAD] = 1'b0;
          end
        end else begin
          res.status = STATUS_BAD_CONV;
        end
      end
    end

    // Fields reported are those parsed up to this character
    if (go_conv) begin
      // conversion path leaves the parse fields untouched
    end else begin
      res_flags = flag_bits_next;
    end

    res.alt_form   = res_flags[FLAG_ALT];
    res.zero_pad   = res_flags[FLAG_ZPAD];
    res.left_align = res_flags[FLAG_LEFT];
    res.space_sign = res_flags[FLAG_BLANK];
    res.plus_sign  = res_flags[FLAG_SIGN];
    res.length_kind = length_code_next;

    w_ext = EXT_W'(width_accum_next);
    p_ext = EXT_W'(prec_accum_next);
    res.field_width = w_ext[WIDTH_W-1:0];
    if (res_pp && !pp_cur) begin
      res.precision = PREC_DEFAULT_F;
    end else if (res_pp) begin
      res.precision = p_ext[PREC_W-1:0];
    end else begin
      res.precision = '1;
    end

    // A closed specification returns everything to the cleared state
    if (emit) begin
      stage_next        = ST_FLAG;
      flag_bits_next    = 5'd0;
      width_accum_next  = '0;
      prec_accum_next   = '0;
      prec_present_next = 1'b0;
      length_code_next  = LEN_NONE;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      stage        <= ST_FLAG;
      flag_bits    <= 5'd0;
      width_accum  <= '0;
      prec_accum   <= '0;
      prec_present <= 1'b0;
      length_code  <= LEN_NONE;
    end else if (advance) begin
      stage        <= stage_next;
      flag_bits    <= flag_bits_next;
      width_accum  <= width_accum_next;
      prec_accum   <= prec_accum_next;
      prec_present <= prec_present_next;
      length_code  <= length_code_next;
    end
  end

endmodule

/* src/printf_spec_parser_unit.sv */
// ----------------------------------------------------------------------------
// printf_spec_parser_unit: format specifier parser
// Parses the characters after a percent sign, one per transaction, and
// returns one result transaction per closed specification.
// ----------------------------------------------------------------------------
//
//   channel | handshake            | payload
//   --------+----------------------+-----------------------------------------
//   input   | in_valid / in_ready  | char_code, first
//   output  | out_valid / out_ready| status, flags, field_width, precision,
//           |                      | length_kind, conversion
//
// Cycles: one character per cycle unless a closing character is held. A
//   character lands in the input register and is parsed there against the
//   spec state; a result is loaded into the output register.
// Reset: synchronous rst clears the parse stage, flags, accumulators and
//   both valid bits; the first character after reset starts a new spec.
// Stalls: the output register alone gates progress; a character that closes
//   a spec waits in the input register while an earlier result is not taken,
//   and characters that produce no result keep flowing meanwhile.
// ----------------------------------------------------------------------------
module printf_spec_parser_unit #(
  parameter int NUMBER_BITS = psp_pkg::NUMBER_BITS_DEF
) (
  input  logic                          clk,
  input  logic                          rst,
  input  logic                          in_valid,
  output logic                          in_ready,
  input  logic [7:0]                    char_code,
  input  logic                          first,
  output logic                          out_valid,
  input  logic                          out_ready,
  output logic [1:0]                    status,
  output logic                          alt_form,
  output logic                          zero_pad,
  output logic                          left_align,
  output logic                          space_sign,
  output logic                          plus_sign,
  output logic [psp_pkg::WIDTH_W-1:0]   field_width,
  output logic signed [psp_pkg::PREC_W-1:0] precision,
  output logic [2:0]                    length_kind,
  output logic [7:0]                    conversion
);
  import psp_pkg::*;

  // Input register
  logic       in_full;
  logic [7:0] char_q;
  logic       first_q;

  // Parse step
  logic       res_emit;
  result_t    res;
  logic       advance;
  logic       out_free;

  // Output register
  result_t    out_q;

  // Hold the character when it closes a spec and the output is occupied
  assign out_free = !out_valid || out_ready;
  assign advance  = in_full && (!res_emit || out_free);
  assign in_ready = !in_full || advance;

  always_ff @(posedge clk) begin
    if (rst) begin
      in_full <= 1'b0;
    end else if (in_valid && in_ready) begin
      in_full <= 1'b1;
    end else if (advance) begin
      in_full <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (in_valid && in_ready) begin
      char_q  <= char_code;
      first_q <= first;
    end
  end

  psp_core #(.NUMBER_BITS(NUMBER_BITS)) u_core (
    .clk       (clk),
    .rst       (rst),
    .advance   (advance),
    .char_code (char_q),
    .first     (first_q),
    .emit      (res_emit),
    .res       (res)
  );

  // Load a new result, or drop the shown one once taken
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (advance && res_emit) begin
      out_valid <= 1'b1;
    end else if (out_ready) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (advance && res_emit) begin
      out_q <= res;
    end
  end

  assign status      = out_q.status;
  assign alt_form    = out_q.alt_form;
  assign zero_pad    = out_q.zero_pad;
  assign left_align  = out_q.left_align;
  assign space_sign  = out_q.space_sign;
  assign plus_sign   = out_q.plus_sign;
  assign field_width = out_q.field_width;
  assign precision   = signed'(out_q.precision);
  assign length_kind = out_q.length_kind;
  assign conversion  = out_q.conversion;

  // A character held for a busy output keeps its payload
  a_hold_input: assert property (@(posedge clk) disable iff (rst)
    in_full && !advance |=> in_full && $stable(char_q) && $stable(first_q))
    else $error("held character changed or was lost");

  // A result produced by the parse step is shown next cycle
  a_result_shown: assert property (@(posedge clk) disable iff (rst)
    advance && res_emit |=> out_valid)
    else $error("parsed result did not reach the output register");

  // Rejected or truncated specs carry no conversion character
  a_reject_no_conv: assert property (@(posedge clk) disable iff (rst)
    out_valid && status != STATUS_OK |-> conversion == 8'd0)
    else $error("non-accepted result carries a conversion");

  // Accepted specs always name a conversion, and no unused status appears
  a_accept_conv: assert property (@(posedge clk) disable iff (rst)
    out_valid |-> (status == STATUS_OK && conversion != 8'd0) ||
                  status == STATUS_EOS || status == STATUS_BAD_CONV)
    else $error("bad status or missing conversion");

  // No result is overwritten before it is taken
  a_no_overwrite: assert property (@(posedge clk) disable iff (rst)
    out_valid && !out_ready |-> !(advance && res_emit))
    else $error("result overwritten while stalled");

endmodule

/* sim/printf_spec_parser_unit_tb.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// printf_spec_parser_unit_tb: self-checking regression for the spec parser
// Streams format characters through the input channel and checks every
// result transaction against a cycle-free software model of the parser.
// The stimulus is a directed run, then random traffic under four idling
// profiles on the two handshakes.
// ----------------------------------------------------------------------------
module printf_spec_parser_unit_tb;
  import psp_pkg::*;

  localparam int NUMBER_BITS = NUMBER_BITS_DEF;
  // Saturation ceiling of the width and precision accumulators.
  localparam logic [63:0] NUM_MAX = (64'd1 << NUMBER_BITS) - 64'd1;
  // Cycles to let pass after the last result.
  localparam int SETTLE_CYCLES = 8;
  localparam int ITEMS_PER_PHASE = 262;
  localparam int REPORT_LIMIT = 10;

  localparam logic [7:0] CH_UNKNOWN = 8'h7A;  // 'z', never a conversion
  localparam logic [7:0] CH_TOP     = 8'hFF;

  logic                      clk;
  logic                      rst = 1'b1;
  logic                      in_valid = 1'b0;
  logic                      in_ready;
  logic [7:0]                char_code = CH_NUL;
  logic                      first = 1'b0;
  logic                      out_valid;
  logic                      out_ready = 1'b0;
  logic [1:0]                status;
  logic                      alt_form;
  logic                      zero_pad;
  logic                      left_align;
  logic                      space_sign;
  logic                      plus_sign;
  logic [WIDTH_W-1:0]        field_width;
  logic signed [PREC_W-1:0]  precision;
  logic [2:0]                length_kind;
  logic [7:0]                conversion;

  // Idling profile: percent of cycles the sender holds off / the receiver
  // drops ready.
  int tx_idle_pct = 0;
  int rx_stall_pct = 0;

  int chars_sent = 0;
  int error_count = 0;

  // Parsed specifications waiting for their result transaction, oldest first.
  result_t pending_specs[$];

  // Model state of the parser, tracked in transaction order.
  stage_t      spec_stage = ST_FLAG;
  logic [4:0]  spec_flags = '0;
  logic [63:0] width_acc = '0;
  logic [63:0] prec_acc = '0;
  logic        prec_present = 1'b0;
  logic [2:0]  len_code = LEN_NONE;

  printf_spec_parser_unit #(
    .NUMBER_BITS(NUMBER_BITS)
  ) dut (
    .clk(clk),
    .rst(rst),
    .in_valid(in_valid),
    .in_ready(in_ready),
    .char_code(char_code),
    .first(first),
    .out_valid(out_valid),
    .out_ready(out_ready),
    .status(status),
    .alt_form(alt_form),
    .zero_pad(zero_pad),
    .left_align(left_align),
    .space_sign(space_sign),
    .plus_sign(plus_sign),
    .field_width(field_width),
    .precision(precision),
    .length_kind(length_kind),
    .conversion(conversion)
  );

  initial begin
    clk = 1'b0;
    forever #5 clk = ~clk;
  end

  // Hard stop: far beyond the slowest legal run of this stimulus.
  initial begin
    #5_000_000;
    $display("printf_spec_parser_unit regression: fail");
    $finish;
  end

  // --------------------------------------------------------------------------
  // Parser model
  // --------------------------------------------------------------------------

  function automatic void clear_spec_state();
    spec_stage = ST_FLAG;
    spec_flags = '0;
    width_acc = '0;
    prec_acc = '0;
    prec_present = 1'b0;
    len_code = LEN_NONE;
  endfunction

  function automatic logic is_dec_digit(input logic [7:0] c);
    return (c >= CH_ZERO) && (c <= CH_NINE);
  endfunction

  // Decimal accumulate that clamps at NUM_MAX instead of wrapping.
  function automatic logic [63:0] add_decimal(input logic [63:0] acc,
                                               input logic [7:0] c);
    logic [63:0] d;
    d = {56'd0, c} - 64'd48;
    if (acc > (NUM_MAX - d) / 64'd10) return NUM_MAX;
    return acc * 64'd10 + d;
  endfunction

  // Close the current spec into a result and start a fresh one.
  function automatic bit close_spec(input logic [1:0] st, input logic [7:0] conv,
                                    output result_t res);
    res.status      = st;
    res.alt_form    = spec_flags[FLAG_ALT];
    res.zero_pad    = spec_flags[FLAG_ZPAD];
    res.left_align  = spec_flags[FLAG_LEFT];
    res.space_sign  = spec_flags[FLAG_BLANK];
    res.plus_sign   = spec_flags[FLAG_SIGN];
    res.field_width = width_acc[WIDTH_W-1:0];
    res.precision   = prec_present ? prec_acc[PREC_W-1:0] : {PREC_W{1'b1}};
    res.length_kind = len_code;
    res.conversion  = conv;
    clear_spec_state();
    return 1'b1;
  endfunction

  function automatic bit take_conversion(input logic [7:0] c, output result_t res);
    logic int_conv;
    logic known;
    int_conv = (c == CH_D) || (c == CH_I) || (c == CH_O) || (c == CH_U) ||
               (c == CH_X_LOW) || (c == CH_X_UP);
    known = int_conv || (c == CH_C) || (c == CH_S) || (c == CH_P) ||
            (c == CH_F) || (c == CH_PERCENT);
    if (!known) return close_spec(STATUS_BAD_CONV, CH_NUL, res);
    // Default precision for f; explicit precision drops zero padding on
    // integer conversions.
    if (!prec_present) begin
      if (c == CH_F) begin
        prec_present = 1'b1;
        prec_acc = {32'd0, PREC_DEFAULT_F};
      end
    end else if (int_conv) begin
      spec_flags[FLAG_ZPAD] = 1'b0;
    end
    return close_spec(STATUS_OK, c, res);
  endfunction

  function automatic bit take_length_char(input logic [7:0] c, output result_t res);
    bit produced;
    produced = 1'b0;
    if (c == CH_LOW_H) begin
      len_code = LEN_H;
      spec_stage = ST_LEN_H;
    end else if (c == CH_LOW_L) begin
      len_code = LEN_L;
      spec_stage = ST_LEN_L;
    end else if (c == CH_UP_L) begin
      len_code = LEN_BIG_L;
      spec_stage = ST_CONV;
    end else begin
      produced = take_conversion(c, res);
    end
    return produced;
  endfunction

  function automatic bit take_width_char(input logic [7:0] c, output result_t res);
    bit produced;
    produced = 1'b0;
    if (is_dec_digit(c)) begin
      width_acc = add_decimal(width_acc, c);
      spec_stage = ST_WIDTH;
    end else if (c == CH_DOT) begin
      prec_present = 1'b1;
      prec_acc = '0;
      spec_stage = ST_PREC;
    end else begin
      produced = take_length_char(c, res);
    end
    return produced;
  endfunction

  // Advance the model by one accepted character; returns 1 when a result
  // transaction is due. Characters foreign to a stage fall through to the
  // later stages within the same step.
  function automatic bit parse_char(input logic [7:0] c, input logic mark,
                                    output result_t res);
    bit produced;
    produced = 1'b0;
    res = '0;
    if (mark) clear_spec_state();
    if (c == CH_NUL) return close_spec(STATUS_EOS, CH_NUL, res);
    case (spec_stage)
      ST_FLAG: begin
        if (c == CH_HASH) spec_flags[FLAG_ALT] = 1'b1;
        else if (c == CH_ZERO) spec_flags[FLAG_ZPAD] = 1'b1;
        else if (c == CH_MINUS) spec_flags[FLAG_LEFT] = 1'b1;
        else if (c == CH_SPACE) spec_flags[FLAG_BLANK] = 1'b1;
        else if (c == CH_PLUS) spec_flags[FLAG_SIGN] = 1'b1;
        else produced = take_width_char(c, res);
      end
      ST_WIDTH: produced = take_width_char(c, res);
      ST_PREC: begin
        if (is_dec_digit(c)) prec_acc = add_decimal(prec_acc, c);
        else produced = take_length_char(c, res);
      end
      ST_LEN_H: begin
        if (c == CH_LOW_H) begin
          len_code = LEN_HH;
          spec_stage = ST_CONV;
        end else begin
          produced = take_conversion(c, res);
        end
      end
      ST_LEN_L: begin
        if (c == CH_LOW_L) begin
          len_code = LEN_LL;
          spec_stage = ST_CONV;
        end else begin
          produced = take_conversion(c, res);
        end
      end
      default: produced = take_conversion(c, res);
    endcase
    return produced;
  endfunction

  // --------------------------------------------------------------------------
  // Checking
  // --------------------------------------------------------------------------

  function automatic string fmt_result(input result_t r);
    return $sformatf("st=%0d flags(#0- +)=%b%b%b%b%b w=%0d p=%0d len=%0d conv=%02h",
                     r.status, r.alt_form, r.zero_pad, r.left_align, r.space_sign,
                     r.plus_sign, r.field_width, $signed(r.precision),
                     r.length_kind, r.conversion);
  endfunction

  // Count every failure; print only the first few.
  task automatic note_failure(input string msg);
    if (error_count < REPORT_LIMIT) $display("ERROR @%0t: %s", $realtime, msg);
    error_count++;
  endtask

  // Receiver: drop ready at the rate of the current profile.
  always @(posedge clk) begin
    out_ready <= ($urandom_range(99) >= rx_stall_pct);
  end

  // Compare every result transaction with the oldest pending spec. Values are
  // sampled at the edge, before any update that the edge itself causes.
  always @(posedge clk) begin : result_checker
    result_t got;
    result_t want;
    if (!rst && out_valid && out_ready) begin
      got = '{status, alt_form, zero_pad, left_align, space_sign, plus_sign,
              field_width, precision, length_kind, conversion};
      if (pending_specs.size() == 0) begin
        note_failure({"result with nothing pending: ", fmt_result(got)});
      end else begin
        want = pending_specs.pop_front();
        if (got.status !== want.status || got.alt_form !== want.alt_form ||
            got.zero_pad !== want.zero_pad || got.left_align !== want.left_align ||
            got.space_sign !== want.space_sign || got.plus_sign !== want.plus_sign ||
            got.field_width !== want.field_width ||
            got.precision !== want.precision ||
            got.length_kind !== want.length_kind ||
            got.conversion !== want.conversion)
          note_failure({"mismatch: expected ", fmt_result(want),
                        " actual ", fmt_result(got)});
      end
    end
  end

  // --------------------------------------------------------------------------
  // Stimulus
  // --------------------------------------------------------------------------

  // Present one character and hold it until the transaction completes. Valid
  // is left high on return so a back-to-back character needs no second
  // assignment in the same step; an idling next call or a drain lowers it.
  task automatic send_char(input logic [7:0] c, input logic mark);
    result_t res;
    if ($urandom_range(99) < tx_idle_pct) begin
      in_valid <= 1'b0;
      do @(posedge clk); while ($urandom_range(99) < tx_idle_pct);
    end
    in_valid  <= 1'b1;
    char_code <= c;
    first     <= mark;
    do @(posedge clk); while (!in_ready);
    chars_sent++;
    if (parse_char(c, mark, res)) pending_specs.push_back(res);
  endtask

  // Hold off the sender until every pending result has come back, then let
  // the pipeline settle.
  task automatic drain_pending();
    in_valid <= 1'b0;
    while (pending_specs.size() != 0) @(posedge clk);
    repeat (SETTLE_CYCLES) @(posedge clk);
  endtask

  // Mostly well-formed specs with random content; the rest is raw noise with
  // random first marks, which also breaks specs in the middle.
  task automatic stream_random_chars(input int count);
    int stop_at;
    int r;
    logic [7:0] text[$];
    stop_at = chars_sent + count;
    while (chars_sent < stop_at) begin
      if ($urandom_range(4) == 0) begin
        repeat ($urandom_range(1, 6))
          send_char(8'($urandom_range(255)), 1'($urandom_range(1)));
      end else begin
        text.delete();
        repeat ($urandom_range(3)) begin
          case ($urandom_range(4))
            0: text.push_back(CH_HASH);
            1: text.push_back(CH_ZERO);
            2: text.push_back(CH_MINUS);
            3: text.push_back(CH_SPACE);
            default: text.push_back(CH_PLUS);
          endcase
        end
        // Width: usually short, now and then long enough to saturate.
        r = $urandom_range(9);
        if (r >= 5)
          repeat (r == 9 ? $urandom_range(9, 12) : $urandom_range(1, 3))
            text.push_back(CH_ZERO + 8'($urandom_range(9)));
        if ($urandom_range(1)) begin
          text.push_back(CH_DOT);
          r = $urandom_range(9);
          repeat (r == 9 ? $urandom_range(10, 12) : $urandom_range(0, 3))
            text.push_back(CH_ZERO + 8'($urandom_range(9)));
        end
        case ($urandom_range(5))
          1: text.push_back(CH_LOW_H);
          2: begin
            text.push_back(CH_LOW_H);
            text.push_back(CH_LOW_H);
          end
          3: text.push_back(CH_LOW_L);
          4: begin
            text.push_back(CH_LOW_L);
            text.push_back(CH_LOW_L);
          end
          5: text.push_back(CH_UP_L);
          default: ;
        endcase
        // Close with a conversion, a stray byte or an early end of string.
        r = $urandom_range(19);
        if (r == 0) text.push_back(8'($urandom_range(255)));
        else if (r == 1) text.push_back(CH_NUL);
        else begin
          case ($urandom_range(10))
            0: text.push_back(CH_C);
            1: text.push_back(CH_S);
            2: text.push_back(CH_P);
            3: text.push_back(CH_D);
            4: text.push_back(CH_I);
            5: text.push_back(CH_O);
            6: text.push_back(CH_U);
            7: text.push_back(CH_X_LOW);
            8: text.push_back(CH_X_UP);
            9: text.push_back(CH_F);
            default: text.push_back(CH_PERCENT);
          endcase
        end
        r = $urandom_range(1);
        foreach (text[i]) send_char(text[i], (i == 0) && (r != 0));
      end
    end
  endtask

  // --------------------------------------------------------------------------
  // Tests
  // --------------------------------------------------------------------------

  // Directed run at full rate: all flags, a saturated width, a dot with no
  // digits under an integer conversion, the f default after a result with no
  // first mark, a first mark in the middle of a spec, an unknown conversion
  // after hh, an early end of string and the top character code.
  task automatic test_directed_specs();
    tx_idle_pct = 0;
    rx_stall_pct = 0;
    send_char(CH_HASH, 1'b1);
    send_char(CH_ZERO, 1'b0);
    send_char(CH_MINUS, 1'b0);
    send_char(CH_SPACE, 1'b0);
    send_char(CH_PLUS, 1'b0);
    repeat (10) send_char(CH_NINE, 1'b0);
    send_char(CH_DOT, 1'b0);
    send_char(CH_D, 1'b0);
    send_char(CH_F, 1'b0);
    send_char(CH_PERCENT, 1'b0);
    send_char(CH_UP_L, 1'b0);
    send_char(CH_LOW_H, 1'b1);
    send_char(CH_LOW_H, 1'b0);
    send_char(CH_UNKNOWN, 1'b0);
    send_char(CH_ZERO, 1'b0);
    send_char(CH_NUL, 1'b0);
    send_char(CH_TOP, 1'b1);
    drain_pending();
  endtask

  // Back-to-back transactions on both sides.
  task automatic test_full_rate_stream();
    tx_idle_pct = 0;
    rx_stall_pct = 0;
    stream_random_chars(ITEMS_PER_PHASE);
    drain_pending();
  endtask

  // Sender idle most of the time.
  task automatic test_sparse_input();
    tx_idle_pct = 78;
    rx_stall_pct = 0;
    stream_random_chars(ITEMS_PER_PHASE);
    drain_pending();
  endtask

  // Receiver stalls most of the time.
  task automatic test_output_backpressure();
    tx_idle_pct = 0;
    rx_stall_pct = 78;
    stream_random_chars(ITEMS_PER_PHASE);
    drain_pending();
  endtask

  // Light idling on both sides.
  task automatic test_mixed_idling();
    tx_idle_pct = 14;
    rx_stall_pct = 14;
    stream_random_chars(ITEMS_PER_PHASE);
    drain_pending();
  endtask

  initial begin
    repeat (12) @(posedge clk);
    rst <= 1'b0;
    test_directed_specs();
    test_full_rate_stream();
    test_sparse_input();
    test_output_backpressure();
    test_mixed_idling();
    if (error_count == 0) begin
      $display("printf_spec_parser_unit regression: pass");
    end else begin
      $display("printf_spec_parser_unit regression: fail");
    end
    $finish;
  end

endmodule

/* files.f */
src/psp_pkg.sv
src/psp_dec_acc.sv
src/psp_core.sv
src/printf_spec_parser_unit.sv
sim/printf_spec_parser_unit_tb.sv
